// ===== rtl/core/wsr_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helpers of the windowed scaler rate block
// no dependencies

package wsr_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int HALF_MAX     = 8;
	localparam int IN_CH        = 8;
	localparam int DEPTH        = 2 * HALF_MAX + 1;

	localparam int AGE_W    = $clog2(DEPTH);
	localparam int SLOT_W   = $clog2(DEPTH);
	localparam int SEEN_W   = $clog2(DEPTH + 1);
	localparam int HW_W     = 4;
	localparam int SEC_W    = 32;
	localparam int US_W     = 20;
	localparam int STAMP_W  = SEC_W + US_W;
	localparam int COUNT_W  = 48;
	localparam int RATE_W   = 48;
	localparam int TIME_W   = 52;
	localparam int DT_W     = TIME_W + 1;
	localparam int DIFF_W   = COUNT_W + 1;
	localparam int ROW_W    = NUM_CHANNELS * COUNT_W;
	localparam int OROW_W   = IN_CH * RATE_W;
	localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int IN_BITS  = STAMP_W + IN_CH * COUNT_W;
	localparam int OUT_BITS = STAMP_W + IN_CH * RATE_W;
	localparam int IN_TD_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TD_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int GAP_W    = 32;

	localparam logic [US_W-1:0]   US_PER_S    = US_W'(1000000);
	localparam logic [HW_W-1:0]   HW_RESET    = HW_W'(2);
	localparam logic [GAP_W-1:0]  GAP_RESET   = GAP_W'(2000000);
	localparam logic [AGE_W-1:0]  HALF_MAX_A  = AGE_W'(HALF_MAX);

	// product m * 1e6 * 256 as dividend
	localparam int MLO_W   = 24;
	localparam int MHI_W   = COUNT_W - MLO_W;
	localparam int PROD_W  = COUNT_W + US_W;
	localparam int NUM_W   = PROD_W + 8;
	localparam int CNT_W   = $clog2(NUM_W);

	typedef logic [1:0] fetch_sel_t;
	localparam fetch_sel_t SEL_CENTER = 2'd0;
	localparam fetch_sel_t SEL_LO     = 2'd1;
	localparam fetch_sel_t SEL_HI     = 2'd2;

	typedef struct packed {
		logic             accept;
		logic             clear_run;
		logic             setup;
		logic [AGE_W-1:0] ac;
		logic [AGE_W-1:0] h;
		logic             fetch;
		fetch_sel_t       sel;
		logic             lo_dec;
		logic             hi_inc;
		logic             rows;
		logic             div_start;
		logic [CH_W-1:0]  ch;
		logic             out_load;
		logic             last;
	} wsr_cmd_t;

	typedef struct packed {
		logic [AGE_W-1:0] known;
		logic             lo_more;
		logic             hi_more;
		logic             dt_zero;
		logic             div_done;
		logic             out_free;
	} wsr_stat_t;

	// ring slot holding the entry of the given age (0 = newest)
	function automatic logic [SLOT_W-1:0] slot_of_age(input logic [SLOT_W-1:0] ws,
			input logic [AGE_W-1:0] age);
		logic [SLOT_W+2:0] sum;
		sum = (SLOT_W+3)'(ws) + (SLOT_W+3)'(2 * DEPTH - 1) - (SLOT_W+3)'(age);
		if (sum >= (SLOT_W+3)'(2 * DEPTH)) begin
			sum = sum - (SLOT_W+3)'(2 * DEPTH);
		end
		if (sum >= (SLOT_W+3)'(DEPTH)) begin
			sum = sum - (SLOT_W+3)'(DEPTH);
		end
		return sum[SLOT_W-1:0];
	endfunction

endpackage

// ===== rtl/core/windowed_scaler_rate.sv =====
`timescale 1ns / 1ps
// windowed scaler rate top level: one entry a transfer in, up to nine results out
// an entry is accepted only while idle: the next entry waits until every result of the
// last one is out, which the output stalls and the bit-serial divider hold up, one division
// for each of the eight channels of a result (none on a zero span)
// reset (arst_n low, asynchronous): run empty, window half-width 2, gap_limit_us 2000000
// depends on wsr_pkg, wsr_ctrl, wsr_datapath

module windowed_scaler_rate import wsr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// entry stream
	input  logic                s_tvalid,
	output logic                s_tready,
	// stamp_seconds, stamp_micros, count_ch0 .. count_ch7, zero pad
	input  logic [IN_TD_W-1:0]  s_tdata,
	// final_entry
	input  logic                s_tlast,
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	// out_seconds, out_micros, rate_ch0 .. rate_ch7, zero pad
	output logic [OUT_TD_W-1:0] m_tdata,
	// zero_interval
	output logic                m_tuser,
	// last_result
	output logic                m_tlast
);

	localparam logic REG_WIN_HALF  = 1'b0;
	localparam logic REG_GAP_LIMIT = 1'b1;

	logic [HW_W-1:0]  win_half_q;
	logic [GAP_W-1:0] gap_limit_q;
	logic             cfg_wr;
	wsr_cmd_t         cmd;
	wsr_stat_t        stat;

	// register file: bit 2 of the address picks the register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_half_q  <= HW_RESET;
			gap_limit_q <= GAP_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WIN_HALF:  win_half_q  <= pwdata[HW_W-1:0];
				REG_GAP_LIMIT: gap_limit_q <= pwdata;
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIN_HALF:  prdata = 32'(win_half_q);
			REG_GAP_LIMIT: prdata = gap_limit_q;
			default:       prdata = '0;
		endcase
	end

	// controller walks the result list of each entry
	wsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.win_half (win_half_q),
		.stat     (stat),
		.cmd      (cmd)
	);

	// rings, time arithmetic, divider and the output register
	wsr_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.gap_limit_us (gap_limit_q),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast)
	);

endmodule

// ===== rtl/core/wsr_div.sv =====
`timescale 1ns / 1ps
// serial rate divider: |diff| * 256e6 / |dt|, one quotient bit a cycle, saturated
// depends on wsr_pkg

module wsr_div import wsr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIFF_W-1:0] diff,
	input  logic signed [DT_W-1:0]   dt,
	output logic                     done,
	output logic [RATE_W-1:0]        rate
);

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_MUL  = 2'd1;
	localparam logic [1:0] D_RUN  = 2'd2;
	localparam logic [1:0] D_FIN  = 2'd3;

	logic [1:0]             state_q;
	logic                   neg_q;
	logic                   over_q;
	logic                   done_q;
	logic [MHI_W-1:0]       mhi_q;
	logic [PROD_W-1:0]      plo_q;
	logic [DT_W-1:0]        d_q;
	logic [NUM_W-1:0]       num_q;
	logic [DT_W-1:0]        rem_q;
	logic [RATE_W-1:0]      quo_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [RATE_W-1:0]      rate_q;

	logic [DIFF_W-1:0]      mag_in;
	logic [DT_W-1:0]        d_in;
	logic [DT_W:0]          rem_n;
	logic                   ge;
	logic                   high;
	logic [PROD_W-1:0]      phi;
	logic [RATE_W-1:0]      lim;
	logic [RATE_W-1:0]      mag;

	always_comb begin
		mag_in = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		d_in   = dt[DT_W-1] ? DT_W'(-dt) : DT_W'(dt);
		rem_n  = {rem_q, num_q[NUM_W-1]};
		ge     = rem_n >= {1'b0, d_q};
		high   = cnt_q >= CNT_W'(RATE_W);
		phi    = PROD_W'(mhi_q * US_PER_S) << MLO_W;
		lim    = neg_q ? (RATE_W'(1) << (RATE_W - 1)) : ((RATE_W'(1) << (RATE_W - 1)) - 1'b1);
		mag    = (over_q || quo_q > lim) ? lim : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= state_q == D_FIN;
			unique case (state_q)
				D_IDLE: if (start) state_q <= D_MUL;
				D_MUL:  state_q <= D_RUN;
				D_RUN:  if (cnt_q == '0) state_q <= D_FIN;
				D_FIN:  state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				neg_q <= diff[DIFF_W-1] ^ dt[DT_W-1];
				mhi_q <= mag_in[COUNT_W-1:MLO_W];
				plo_q <= PROD_W'(mag_in[MLO_W-1:0] * US_PER_S);
				d_q   <= d_in;
			end
			D_MUL: begin
				num_q  <= {phi + plo_q, 8'd0};
				rem_q  <= '0;
				quo_q  <= '0;
				over_q <= 1'b0;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end
			D_RUN: begin
				num_q  <= num_q << 1;
				rem_q  <= ge ? DT_W'(rem_n - {1'b0, d_q}) : rem_n[DT_W-1:0];
				quo_q  <= {quo_q[RATE_W-2:0], ge && !high};
				over_q <= over_q || (ge && high);
				cnt_q  <= cnt_q - 1'b1;
			end
			D_FIN: rate_q <= neg_q ? RATE_W'(-mag) : mag;
			default: ;
		endcase
	end

	assign done = done_q;
	assign rate = rate_q;

endmodule

// ===== rtl/core/wsr_datapath.sv =====
`timescale 1ns / 1ps
// entry rings, time fetch pipeline, window edge checks, rate store and output register
// depends on wsr_pkg and wsr_div

module wsr_datapath import wsr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  wsr_cmd_t            cmd,
	output wsr_stat_t           stat,
	input  logic [GAP_W-1:0]    gap_limit_us,
	input  logic [IN_TD_W-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_TD_W-1:0] m_tdata,
	output logic                m_tuser,
	output logic                m_tlast
);

	logic [STAMP_W-1:0] stamp_mem_q [DEPTH];
	logic [ROW_W-1:0]   count_mem_q [DEPTH];

	logic [SLOT_W-1:0]  ws_q;
	logic [SEEN_W-1:0]  seen_q;
	logic [AGE_W-1:0]   ac_q;
	logic [AGE_W-1:0]   lo_age_q;
	logic [AGE_W-1:0]   hi_age_q;

	logic [STAMP_W-1:0] stamp_s1;
	fetch_sel_t         sel_s1;
	logic               vld_s1;
	logic [TIME_W-1:0]  prod_s2;
	logic [US_W-1:0]    us_s2;
	fetch_sel_t         sel_s2;
	logic               vld_s2;

	logic [TIME_W-1:0]  tc_q;
	logic [TIME_W-1:0]  tlo_q;
	logic [TIME_W-1:0]  thi_q;
	logic [STAMP_W-1:0] cstamp_q;
	logic [ROW_W-1:0]   hi_row_q;
	logic [ROW_W-1:0]   lo_row_q;
	logic signed [DT_W-1:0] dt_q;
	logic [RATE_W-1:0]  rate_q [IN_CH];
	logic [CH_W-1:0]    ch_q;

	logic                out_vld_q;
	logic [OUT_TD_W-1:0] out_data_q;
	logic                out_zero_q;
	logic                out_last_q;

	logic [AGE_W-1:0]   fetch_age;
	logic [AGE_W:0]     lo_sum;
	logic [AGE_W-1:0]   known;
	logic signed [TIME_W+1:0] lo_dist;
	logic signed [TIME_W+1:0] hi_dist;
	logic signed [TIME_W+1:0] gap_s;
	logic [COUNT_W-1:0] hi_cnt;
	logic [COUNT_W-1:0] lo_cnt;
	logic signed [DIFF_W-1:0] diff;
	logic               div_done;
	logic [RATE_W-1:0]  div_rate;
	logic [OROW_W-1:0]  rate_row;

	always_comb begin
		unique case (cmd.sel)
			SEL_CENTER: fetch_age = ac_q;
			SEL_LO:     fetch_age = lo_age_q;
			SEL_HI:     fetch_age = hi_age_q;
			default:    fetch_age = ac_q;
		endcase
		known   = AGE_W'(seen_q - 1'b1);
		lo_sum  = (AGE_W+1)'(cmd.ac) + (AGE_W+1)'(cmd.h);
		lo_dist = $signed({2'b00, tc_q}) - $signed({2'b00, tlo_q});
		hi_dist = $signed({2'b00, thi_q}) - $signed({2'b00, tc_q});
		gap_s   = $signed((TIME_W+2)'(gap_limit_us));
		hi_cnt  = hi_row_q[cmd.ch*COUNT_W +: COUNT_W];
		lo_cnt  = lo_row_q[cmd.ch*COUNT_W +: COUNT_W];
		diff    = $signed({1'b0, hi_cnt}) - $signed({1'b0, lo_cnt});
		for (int k = 0; k < IN_CH; k++) begin
			rate_row[k*RATE_W +: RATE_W] = rate_q[k];
		end
	end

	assign stat.known    = known;
	assign stat.lo_more  = (lo_age_q > ac_q) && !(lo_dist < gap_s);
	assign stat.hi_more  = (hi_age_q < ac_q) && !(hi_dist < gap_s);
	assign stat.dt_zero  = dt_q == '0;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_vld_q || m_tready;

	// rings
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			stamp_mem_q[ws_q] <= {s_tdata[SEC_W-1:0], s_tdata[SEC_W +: US_W]};
			count_mem_q[ws_q] <= s_tdata[STAMP_W +: ROW_W];
		end
		if (cmd.fetch) begin
			stamp_s1 <= stamp_mem_q[slot_of_age(ws_q, fetch_age)];
		end
		if (cmd.rows) begin
			hi_row_q <= count_mem_q[slot_of_age(ws_q, hi_age_q)];
			lo_row_q <= count_mem_q[slot_of_age(ws_q, lo_age_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q      <= '0;
			seen_q    <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.clear_run) begin
				ws_q   <= '0;
				seen_q <= '0;
			end else if (cmd.accept) begin
				ws_q <= (ws_q == SLOT_W'(DEPTH - 1)) ? '0 : ws_q + 1'b1;
				if (seen_q < SEEN_W'(DEPTH)) seen_q <= seen_q + 1'b1;
			end
			vld_s1 <= cmd.fetch;
			vld_s2 <= vld_s1;
			if (cmd.out_load) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	// time in microseconds, three stages
	always_ff @(posedge clk) begin
		sel_s1  <= cmd.sel;
		sel_s2  <= sel_s1;
		prod_s2 <= TIME_W'(stamp_s1[STAMP_W-1:US_W] * US_PER_S);
		us_s2   <= stamp_s1[US_W-1:0];
		if (vld_s1 && sel_s1 == SEL_CENTER) cstamp_q <= stamp_s1;
		if (vld_s2) begin
			unique case (sel_s2)
				SEL_CENTER: tc_q  <= prod_s2 + TIME_W'(us_s2);
				SEL_LO:     tlo_q <= prod_s2 + TIME_W'(us_s2);
				SEL_HI:     thi_q <= prod_s2 + TIME_W'(us_s2);
				default:    ;
			endcase
		end
	end

	// window edges and rates
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			ac_q     <= cmd.ac;
			lo_age_q <= (lo_sum < (AGE_W+1)'(known)) ? lo_sum[AGE_W-1:0] : known;
			hi_age_q <= (cmd.ac >= cmd.h) ? AGE_W'(cmd.ac - cmd.h) : '0;
			for (int k = 0; k < IN_CH; k++) rate_q[k] <= '0;
		end else begin
			if (cmd.lo_dec) lo_age_q <= lo_age_q - 1'b1;
			if (cmd.hi_inc) hi_age_q <= hi_age_q + 1'b1;
			if (div_done) rate_q[ch_q] <= div_rate;
		end
		if (cmd.rows) dt_q <= $signed({1'b0, thi_q}) - $signed({1'b0, tlo_q});
		if (cmd.div_start) ch_q <= cmd.ch;
		if (cmd.out_load) begin
			out_data_q <= OUT_TD_W'({rate_row, cstamp_q[US_W-1:0],
				cstamp_q[STAMP_W-1:US_W]});
			out_zero_q <= dt_q == '0;
			out_last_q <= cmd.last;
		end
	end

	wsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.diff   (diff),
		.dt     (dt_q),
		.done   (div_done),
		.rate   (div_rate)
	);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_zero_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== rtl/core/wsr_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences the results of one entry, edge trimming and channel divisions
// depends on wsr_pkg

module wsr_ctrl import wsr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            s_tlast,
	input  logic [HW_W-1:0] win_half,
	input  wsr_stat_t       stat,
	output wsr_cmd_t        cmd
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_START = 5'd1;
	localparam logic [4:0] S_SETUP = 5'd2;
	localparam logic [4:0] S_FC    = 5'd3;
	localparam logic [4:0] S_FCW1  = 5'd4;
	localparam logic [4:0] S_FCW2  = 5'd5;
	localparam logic [4:0] S_FL    = 5'd6;
	localparam logic [4:0] S_FLW1  = 5'd7;
	localparam logic [4:0] S_FLW2  = 5'd8;
	localparam logic [4:0] S_LCHK  = 5'd9;
	localparam logic [4:0] S_FH    = 5'd10;
	localparam logic [4:0] S_FHW1  = 5'd11;
	localparam logic [4:0] S_FHW2  = 5'd12;
	localparam logic [4:0] S_HCHK  = 5'd13;
	localparam logic [4:0] S_ROWS  = 5'd14;
	localparam logic [4:0] S_ROWSW = 5'd15;
	localparam logic [4:0] S_DIV   = 5'd16;
	localparam logic [4:0] S_DIVW  = 5'd17;
	localparam logic [4:0] S_OUT   = 5'd18;
	localparam logic [4:0] S_NEXT  = 5'd19;

	logic [4:0]       state_q, state_d;
	logic [AGE_W-1:0] h_q;
	logic [AGE_W-1:0] ac_q, ac_d;
	logic             fin_q;
	logic             flush_q, flush_d;
	logic             last_q, last_d;
	logic [CH_W-1:0]  ch_q, ch_d;

	logic [AGE_W-1:0] h_in;
	logic [AGE_W-1:0] flush_start;

	always_comb begin
		h_in = (AGE_W'(win_half) > HALF_MAX_A) ? HALF_MAX_A : AGE_W'(win_half);
		flush_start = (h_q - 1'b1 < stat.known) ? AGE_W'(h_q - 1'b1) : stat.known;

		state_d = state_q;
		ac_d    = ac_q;
		flush_d = flush_q;
		last_d  = last_q;
		ch_d    = ch_q;
		cmd     = '0;
		cmd.ac  = ac_q;
		cmd.h   = h_q;
		cmd.ch  = ch_q;
		cmd.last = last_q;

		unique case (state_q)
			S_IDLE: begin
				cmd.accept = s_tvalid;
				if (s_tvalid) begin
					flush_d = 1'b0;
					state_d = S_START;
				end
			end
			S_START, S_NEXT: begin
				priority if (state_q == S_START && stat.known >= h_q) begin
					ac_d    = h_q;
					flush_d = 1'b0;
					last_d  = fin_q && h_q == '0;
					state_d = S_SETUP;
				end else if (state_q == S_NEXT && flush_q && ac_q != '0) begin
					ac_d    = ac_q - 1'b1;
					last_d  = ac_q == AGE_W'(1);
					state_d = S_SETUP;
				end else if (!flush_q && fin_q && h_q != '0) begin
					ac_d    = flush_start;
					flush_d = 1'b1;
					last_d  = flush_start == '0;
					state_d = S_SETUP;
				end else begin
					cmd.clear_run = fin_q;
					state_d = S_IDLE;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d = S_FC;
			end
			S_FC: begin
				cmd.fetch = 1'b1;
				cmd.sel   = SEL_CENTER;
				state_d   = S_FCW1;
			end
			S_FCW1: state_d = S_FCW2;
			S_FCW2: state_d = S_FL;
			S_FL: begin
				cmd.fetch = 1'b1;
				cmd.sel   = SEL_LO;
				state_d   = S_FLW1;
			end
			S_FLW1: state_d = S_FLW2;
			S_FLW2: state_d = S_LCHK;
			S_LCHK: begin
				if (stat.lo_more) begin
					cmd.lo_dec = 1'b1;
					state_d = S_FL;
				end else begin
					state_d = S_FH;
				end
			end
			S_FH: begin
				cmd.fetch = 1'b1;
				cmd.sel   = SEL_HI;
				state_d   = S_FHW1;
			end
			S_FHW1: state_d = S_FHW2;
			S_FHW2: state_d = S_HCHK;
			S_HCHK: begin
				if (stat.hi_more) begin
					cmd.hi_inc = 1'b1;
					state_d = S_FH;
				end else begin
					state_d = S_ROWS;
				end
			end
			S_ROWS: begin
				cmd.rows = 1'b1;
				state_d = S_ROWSW;
			end
			S_ROWSW: begin
				ch_d = '0;
				state_d = stat.dt_zero ? S_OUT : S_DIV;
			end
			S_DIV: begin
				cmd.div_start = 1'b1;
				state_d = S_DIVW;
			end
			S_DIVW: begin
				if (stat.div_done) begin
					if (ch_q == CH_W'(NUM_CHANNELS - 1)) begin
						state_d = S_OUT;
					end else begin
						ch_d = ch_q + 1'b1;
						state_d = S_DIV;
					end
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_NEXT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign s_tready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			h_q     <= '0;
			ac_q    <= '0;
			fin_q   <= 1'b0;
			flush_q <= 1'b0;
			last_q  <= 1'b0;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			ac_q    <= ac_d;
			flush_q <= flush_d;
			last_q  <= last_d;
			ch_q    <= ch_d;
			if (state_q == S_IDLE && s_tvalid) begin
				h_q   <= h_in;
				fin_q <= s_tlast;
			end
		end
	end

endmodule
